@@ sv/l2hist_pkg.sv @@
// l2hist_pkg: shared types, op codes, register indexes and constants
// for the log2 binned event histogram; no dependencies
package l2hist_pkg;

    localparam int VALUE_W    = 64;
    localparam int COUNT_W    = 39;
    localparam int OP_W       = 3;
    localparam int SRC_W      = 2;
    localparam int CTR_W      = 32;
    localparam int LG_W       = 6;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam int NUM_THRESH = 4;

    localparam int DEF_SOURCES    = 4;
    localparam int DEF_SIZE_BINS  = 32;
    localparam int DEF_DELAY_BINS = 16;

    typedef enum logic [OP_W-1:0] {
        OP_REC_SIZE      = 3'd0,
        OP_REC_DELAY     = 3'd1,
        OP_TOTAL         = 3'd2,
        OP_TOTAL_BY_SIZE = 3'd3,
        OP_SRC_TOTAL     = 3'd4,
        OP_SRC_BY_SIZE   = 3'd5,
        OP_CLEAR         = 3'd6
    } op_t;

    localparam logic [CFG_IDX_W-1:0] CFG_PAUSED      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESH_0    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESH_LAST = 3'd4;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [SRC_W-1:0]   source;
        logic [VALUE_W-1:0] value;
    } evt_t;

    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic               trace_hit;
    } res_t;

    // source index folded into the configured number of sources
    function automatic logic [SRC_W-1:0] src_wrap(input logic [SRC_W-1:0] s, input int n);
        logic [SRC_W-1:0] r;
        priority if (n >= 4)
            r = s;
        else if (n == 3)
            r = (s == 2'd3) ? 2'd0 : s;
        else if (n == 2)
            r = {1'b0, s[0]};
        else
            r = '0;
        return r;
    endfunction

endpackage

@@ sv/l2hist_ram.sv @@
// l2hist_ram: generic single write port, single read port ram
// with registered read data; no dependencies
module l2hist_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ sv/log2_binned_event_histogram.sv @@
// log2_binned_event_histogram: top level, sequencer, log2 unit and registers
// depends on l2hist_pkg and l2hist_ram
//
// usage
// - evt channel (valid/ready) carries one op per beat: record size, record
//   delay, four kinds of size-histogram query, or clear
// - res channel (valid/ready) returns exactly one beat per op: count holds the
//   query sum, trace_hit flags a size record that met its source threshold
// - cfg port: write enable, register index, data; to be written only while
//   idle, by the user; the block itself does not enforce this
// - one op at a time; evt_ready is high only while the sequencer is idle,
//   but an op may be taken while the previous result still waits on res
// - records and by-size queries: a 6-step shared log2 shift/compare unit
//   bins the value, then a record does one counter ram read and update
//     paused record or unused op: goes straight to the result
//     per-bin queries: read, then accumulate, one bin after another
//     clear: one ram row per cycle over max(SOURCES*SIZE_BINS,
//     SOURCES*DELAY_BINS) rows
// - reset: registers clear, then a sweep zeroes both counter rams over
//   max(SOURCES*SIZE_BINS, SOURCES*DELAY_BINS) rows with evt_ready low;
//   cfg writes are taken during the sweep
// - receiver stall: the result waits in the res register; the next op is
//   still taken and runs until its own result is ready, then holds there
module log2_binned_event_histogram #(
    parameter int SOURCES    = l2hist_pkg::DEF_SOURCES,
    parameter int SIZE_BINS  = l2hist_pkg::DEF_SIZE_BINS,
    parameter int DELAY_BINS = l2hist_pkg::DEF_DELAY_BINS
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  evt_valid,
    output logic                                  evt_ready,
    input  l2hist_pkg::evt_t                      evt,
    output logic                                  res_valid,
    input  logic                                  res_ready,
    output l2hist_pkg::res_t                      res,
    input  logic                                  cfg_we,
    input  logic [l2hist_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [l2hist_pkg::CFG_DATA_W-1:0]     cfg_data
);

    import l2hist_pkg::*;

    localparam int SIZE_DEPTH  = SOURCES * SIZE_BINS;
    localparam int DELAY_DEPTH = SOURCES * DELAY_BINS;
    localparam int MAX_DEPTH   = (SIZE_DEPTH > DELAY_DEPTH) ? SIZE_DEPTH : DELAY_DEPTH;
    localparam int SIZE_AW     = $clog2(SIZE_DEPTH);
    localparam int DELAY_AW    = $clog2(DELAY_DEPTH);
    localparam int ADDR_W      = $clog2(MAX_DEPTH);
    localparam int REM_W       = $clog2(SIZE_DEPTH + 1);
    localparam int NB_W        = 7;
    localparam int K_W         = 3;
    localparam logic [K_W-1:0] LOG_LAST = K_W'(LG_W - 1);

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_LOG,
        ST_BIN,
        ST_READ,
        ST_UPDATE,
        ST_CLEAR,
        ST_DONE
    } state_t;

    state_t               state_reg;
    logic [OP_W-1:0]      op_reg;
    logic [SRC_W-1:0]     src_reg;
    logic [VALUE_W-1:0]   v_reg;
    logic [LG_W-1:0]      lg_reg;
    logic [K_W-1:0]       k_reg;
    logic [ADDR_W-1:0]    addr_reg;
    logic [ADDR_W-1:0]    step_reg;
    logic [REM_W-1:0]     rem_reg;
    logic [COUNT_W-1:0]   acc_reg;
    logic                 hit_reg;
    logic                 res_valid_reg;
    res_t                 res_reg;
    logic                 paused_reg;
    logic [VALUE_W-1:0]   thresh_reg [NUM_THRESH];

    // log2 unit
    logic [LG_W-1:0]      sh;
    logic [VALUE_W-1:0]   v_shift;
    logic [VALUE_W-1:0]   v_next;
    logic [LG_W-1:0]      lg_next;
    logic [NB_W-1:0]      nbins;
    logic [LG_W-1:0]      bin;

    // addressing and ram ports
    logic [SRC_W-1:0]     evt_src;
    logic [VALUE_W-1:0]   evt_th;
    logic [ADDR_W-1:0]    evt_size_base;
    logic [ADDR_W-1:0]    size_base;
    logic [ADDR_W-1:0]    delay_base;
    logic                 sweep;
    logic                 addr_in_size;
    logic                 addr_in_delay;
    logic                 size_we;
    logic                 delay_we;
    logic [CTR_W-1:0]     size_wdata;
    logic [CTR_W-1:0]     delay_wdata;
    logic [CTR_W-1:0]     size_rdata;
    logic [CTR_W-1:0]     delay_rdata;
    logic [1:0]           th_idx;

    // one binary-search step of floor(log2): 32, 16, 8, 4, 2, 1
    always_comb
    begin
        sh      = 6'd32 >> k_reg;
        v_shift = v_reg >> sh;
        if (v_shift != '0)
        begin
            v_next  = v_shift;
            lg_next = lg_reg + sh;
        end
        else
        begin
            v_next  = v_reg;
            lg_next = lg_reg;
        end
    end

    // top bin saturates; delay records use their own bin count
    always_comb
    begin
        nbins = (op_reg == OP_REC_DELAY) ? NB_W'(DELAY_BINS) : NB_W'(SIZE_BINS);
        bin   = ({1'b0, lg_reg} >= nbins) ? LG_W'(nbins - NB_W'(1)) : lg_reg;
    end

    assign evt_src       = src_wrap(evt.source, SOURCES);
    assign evt_th        = thresh_reg[evt_src];
    assign evt_size_base = ADDR_W'(evt_src * SIZE_BINS);
    assign size_base     = ADDR_W'(src_reg * SIZE_BINS);
    assign delay_base    = ADDR_W'(src_reg * DELAY_BINS);
    assign th_idx        = 2'(cfg_index - CFG_THRESH_0);

    assign sweep         = (state_reg == ST_INIT) || (state_reg == ST_CLEAR);
    assign addr_in_size  = {1'b0, addr_reg} < (ADDR_W + 1)'(SIZE_DEPTH);
    assign addr_in_delay = {1'b0, addr_reg} < (ADDR_W + 1)'(DELAY_DEPTH);

    // sweep writes zeros, record update writes the incremented counter
    assign size_we     = (sweep && addr_in_size) ||
                         (state_reg == ST_UPDATE && op_reg == OP_REC_SIZE);
    assign delay_we    = (sweep && addr_in_delay) ||
                         (state_reg == ST_UPDATE && op_reg == OP_REC_DELAY);
    assign size_wdata  = sweep ? '0 : size_rdata + CTR_W'(1);
    assign delay_wdata = sweep ? '0 : delay_rdata + CTR_W'(1);

    l2hist_ram #(
        .WIDTH (CTR_W),
        .DEPTH (SIZE_DEPTH)
    ) u_size_ram (
        .clk   (clk),
        .we    (size_we),
        .waddr (addr_reg[SIZE_AW-1:0]),
        .wdata (size_wdata),
        .raddr (addr_reg[SIZE_AW-1:0]),
        .rdata (size_rdata)
    );

    l2hist_ram #(
        .WIDTH (CTR_W),
        .DEPTH (DELAY_DEPTH)
    ) u_delay_ram (
        .clk   (clk),
        .we    (delay_we),
        .waddr (addr_reg[DELAY_AW-1:0]),
        .wdata (delay_wdata),
        .raddr (addr_reg[DELAY_AW-1:0]),
        .rdata (delay_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            op_reg        <= '0;
            src_reg       <= '0;
            v_reg         <= '0;
            lg_reg        <= '0;
            k_reg         <= '0;
            addr_reg      <= '0;
            step_reg      <= '0;
            rem_reg       <= '0;
            acc_reg       <= '0;
            hit_reg       <= 1'b0;
            res_valid_reg <= 1'b0;
            res_reg       <= '0;
            paused_reg    <= 1'b0;
            for (int i = 0; i < NUM_THRESH; i++)
            begin
                thresh_reg[i] <= '0;
            end
        end
        else
        begin
            // register writes
            if (cfg_we)
            begin
                if (cfg_index == CFG_PAUSED)
                begin
                    paused_reg <= cfg_data[0];
                end
                else if (cfg_index >= CFG_THRESH_0 && cfg_index <= CFG_THRESH_LAST)
                begin
                    thresh_reg[th_idx] <= cfg_data;
                end
            end

            // the done state refills the res register itself
            if (res_valid_reg && res_ready && state_reg != ST_DONE)
            begin
                res_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_INIT:
                begin
                    if (addr_reg == ADDR_W'(MAX_DEPTH - 1))
                    begin
                        addr_reg  <= '0;
                        state_reg <= ST_IDLE;
                    end
                    else
                    begin
                        addr_reg <= addr_reg + ADDR_W'(1);
                    end
                end
                ST_CLEAR:
                begin
                    if (addr_reg == ADDR_W'(MAX_DEPTH - 1))
                    begin
                        addr_reg  <= '0;
                        state_reg <= ST_DONE;
                    end
                    else
                    begin
                        addr_reg <= addr_reg + ADDR_W'(1);
                    end
                end
                ST_IDLE:
                begin
                    if (evt_valid)
                    begin
                        op_reg   <= evt.op;
                        src_reg  <= evt_src;
                        v_reg    <= evt.value;
                        lg_reg   <= '0;
                        k_reg    <= '0;
                        acc_reg  <= '0;
                        step_reg <= ADDR_W'(1);
                        // only an unpaused size record can flag a trace hit
                        hit_reg  <= (evt.op == OP_REC_SIZE) && !paused_reg &&
                                    (evt_th != '0) && (evt.value >= evt_th);
                        // source total walks from that source's first bin
                        addr_reg <= (evt.op == OP_SRC_TOTAL) ? evt_size_base : '0;
                        rem_reg  <= (evt.op == OP_TOTAL)     ? REM_W'(SIZE_DEPTH) :
                                    (evt.op == OP_SRC_TOTAL) ? REM_W'(SIZE_BINS)  :
                                                               REM_W'(1);
                        unique case (evt.op)
                            OP_REC_SIZE, OP_REC_DELAY:
                            begin
                                state_reg <= paused_reg ? ST_DONE : ST_LOG;
                            end
                            OP_TOTAL, OP_SRC_TOTAL:
                            begin
                                state_reg <= ST_READ;
                            end
                            OP_TOTAL_BY_SIZE, OP_SRC_BY_SIZE:
                            begin
                                state_reg <= ST_LOG;
                            end
                            OP_CLEAR:
                            begin
                                state_reg <= ST_CLEAR;
                            end
                            default:
                            begin
                                state_reg <= ST_DONE;
                            end
                        endcase
                    end
                end
                ST_LOG:
                begin
                    v_reg  <= v_next;
                    lg_reg <= lg_next;
                    k_reg  <= k_reg + K_W'(1);
                    if (k_reg == LOG_LAST)
                    begin
                        state_reg <= ST_BIN;
                    end
                end
                ST_BIN:
                begin
                    unique case (op_reg)
                        OP_REC_DELAY:
                        begin
                            addr_reg <= delay_base + ADDR_W'(bin);
                        end
                        OP_TOTAL_BY_SIZE:
                        begin
                            addr_reg <= ADDR_W'(bin);
                            step_reg <= ADDR_W'(SIZE_BINS);
                            rem_reg  <= REM_W'(SOURCES);
                        end
                        default:
                        begin
                            addr_reg <= size_base + ADDR_W'(bin);
                        end
                    endcase
                    state_reg <= ST_READ;
                end
                ST_READ:
                begin
                    state_reg <= ST_UPDATE;
                end
                ST_UPDATE:
                begin
                    if (op_reg == OP_REC_SIZE || op_reg == OP_REC_DELAY)
                    begin
                        state_reg <= ST_DONE;
                    end
                    else
                    begin
                        acc_reg <= acc_reg + COUNT_W'(size_rdata);
                        if (rem_reg == REM_W'(1))
                        begin
                            state_reg <= ST_DONE;
                        end
                        else
                        begin
                            rem_reg   <= rem_reg - REM_W'(1);
                            addr_reg  <= addr_reg + step_reg;
                            state_reg <= ST_READ;
                        end
                    end
                end
                ST_DONE:
                begin
                    if (!res_valid_reg || res_ready)
                    begin
                        res_reg.count     <= acc_reg;
                        res_reg.trace_hit <= hit_reg;
                        res_valid_reg     <= 1'b1;
                        addr_reg          <= '0;
                        state_reg         <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign evt_ready = (state_reg == ST_IDLE);
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // a record beat goes straight to binning, or to the result when paused
    a_record_path: assert property (@(posedge clk) disable iff (!rst_n)
        (evt_valid && evt_ready && (evt.op == OP_REC_SIZE || evt.op == OP_REC_DELAY))
        |=> (state_reg == ST_LOG || state_reg == ST_DONE))
        else $error("record beat took an unexpected path");

    // the bin walk never reads with no bins left
    a_rem_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ) |-> (rem_reg != '0))
        else $error("bin walk read with zero bins remaining");

    // a trace hit only comes from a size record, which carries no count
    a_hit_no_count: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.trace_hit) |-> (res.count == '0))
        else $error("trace hit together with a nonzero count");

    // counters change only in a sweep or a record update
    a_write_window: assert property (@(posedge clk) disable iff (!rst_n)
        (size_we || delay_we) |-> (sweep || state_reg == ST_UPDATE))
        else $error("counter ram written outside sweep or update");

endmodule
